// ===== rtl/sdfp_pkg.sv =====
package sdfp_pkg;

  // Sizes of the dimmer.
  localparam int unsigned SeqLen    = 32;
  localparam int unsigned Slots     = 8;
  localparam int unsigned DutyFull  = 8191;

  localparam int unsigned LevelW    = 6;
  localparam int unsigned SlotW     = 3;
  localparam int unsigned DutyW     = 13;
  localparam int unsigned SeqShift  = $clog2(SeqLen);
  localparam int unsigned ProdW     = LevelW + 16;

  localparam logic [1:0]  FadeDivLast = 2'd3;
  localparam logic [1:0]  IdDivLast   = 2'd3;

  // Input commands.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_SET   = 2'd1;
  localparam logic [1:0] CMD_APPLY = 2'd2;
  localparam logic [1:0] CMD_FADE  = 2'd3;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_MAX_LEVEL    = 2'd0,
    CFG_ID_SLOT      = 2'd1,
    CFG_NATURAL_SLOT = 2'd2,
    CFG_ENV_SLOT     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] level;
  } sdfp_in_t;

  typedef struct packed {
    logic              duty_write;
    logic [DutyW-1:0]  duty_value;
    logic              id_due;
    logic              natural_due;
    logic              env_due;
    logic [LevelW-1:0] light_now;
    logic [SlotW-1:0]  slot_now;
  } sdfp_out_t;

  typedef struct packed {
    logic [LevelW-1:0] max_level;
    logic [SlotW-1:0]  id_slot;
    logic [SlotW-1:0]  natural_slot;
    logic [SlotW-1:0]  env_slot;
  } sdfp_cfg_t;

  // Working state of the dimmer. A cleared duty_valid means no duty has
  // been written since reset.
  typedef struct packed {
    logic              skip_phase;
    logic [SlotW-1:0]  slot;
    logic [1:0]        fade_div;
    logic [1:0]        id_div;
    logic              natural_div;
    logic              update_div;
    logic [LevelW-1:0] light;
    logic [LevelW-1:0] target;
    logic [LevelW-1:0] on_count;
    logic              duty_valid;
    logic [DutyW-1:0]  duty;
  } sdfp_state_t;

  localparam sdfp_cfg_t CFG_RESET = '{
    max_level:    LevelW'(32),
    id_slot:      SlotW'(0),
    natural_slot: SlotW'(1),
    env_slot:     SlotW'(2)
  };

  localparam sdfp_state_t STATE_RESET = '0;

  // Next slot on the ring.
  function automatic logic [SlotW-1:0] slot_next(input logic [SlotW-1:0] slot);
    logic [SlotW-1:0] r;
    if (slot == SlotW'(Slots - 1)) begin
      r = '0;
    end else begin
      r = slot + 1'b1;
    end
    return r;
  endfunction

  // Duty for an ON count: count * full scale / sequence length.
  function automatic logic [DutyW-1:0] duty_of(input logic [LevelW-1:0] count);
    logic [ProdW-1:0] prod;
    prod = ProdW'(count) * ProdW'(DutyFull);
    return DutyW'(prod >> SeqShift);
  endfunction

endpackage

// ===== rtl/slotted_dimmer_fade_pwm.sv =====
// Input transactions pass through the input register, then the result register.
// Throughput: one transaction per cycle unless the result side stalls; the input
// and result registers each take a new transaction when the next stage moves.
// Reset (rst_ni low, asynchronous) empties both stages, restores the
// configuration defaults and clears the dimmer state; no duty is written yet.
module slotted_dimmer_fade_pwm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sdfp_pkg::sdfp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sdfp_pkg::sdfp_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [5:0]          cfg_data_i
);
  import sdfp_pkg::*;

  logic        in_valid_q;
  sdfp_in_t    in_q;
  logic        out_valid_q;
  sdfp_out_t   out_q;
  sdfp_cfg_t   cfg_q, cfg_d;
  sdfp_state_t state_q, state_d;
  sdfp_out_t   res;
  logic        adv;
  logic        step;

  // The result register moves when empty or taken; the input stage follows.
  assign adv        = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && adv;
  assign in_ready_o = !in_valid_q || adv;

  sdfp_step u_step (
    .cfg_i  (cfg_q),
    .cur_i  (state_q),
    .item_i (in_q),
    .nxt_o  (state_d),
    .res_o  (res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Dimmer state advances once per transaction leaving the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (step) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_MAX_LEVEL:    cfg_d.max_level    = cfg_data_i[LevelW-1:0];
        CFG_ID_SLOT:      cfg_d.id_slot      = cfg_data_i[SlotW-1:0];
        CFG_NATURAL_SLOT: cfg_d.natural_slot = cfg_data_i[SlotW-1:0];
        CFG_ENV_SLOT:     cfg_d.env_slot     = cfg_data_i[SlotW-1:0];
        default:          cfg_d              = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

`ifndef SYNTHESIS
  // At most one slot strobe fires for a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({out_data_o.id_due, out_data_o.natural_due,
                              out_data_o.env_due}))
    else $error("more than one slot strobe in a result");

  // The dimmer state only changes when a transaction is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step |=> $stable(state_q))
    else $error("dimmer state changed without a transaction");

  // A duty write leaves the written flag set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.duty_write |-> state_q.duty_valid)
    else $error("duty written but no duty recorded");

  // A held transaction in the input register does not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !adv |=> $stable(in_q) && in_valid_q)
    else $error("stalled input register changed");
`endif

endmodule

// ===== rtl/sdfp_step.sv =====
module sdfp_step (
  input  sdfp_pkg::sdfp_cfg_t   cfg_i,
  input  sdfp_pkg::sdfp_state_t cur_i,
  input  sdfp_pkg::sdfp_in_t    item_i,
  output sdfp_pkg::sdfp_state_t nxt_o,
  output sdfp_pkg::sdfp_out_t   res_o
);
  import sdfp_pkg::*;

  logic             fade;
  logic             latch;
  logic             apply;
  logic             id_due;
  logic             natural_due;
  logic             env_due;
  logic             write;
  logic [DutyW-1:0] duty;
  sdfp_state_t      nxt;

  always_comb begin
    nxt         = cur_i;
    fade        = 1'b0;
    latch       = 1'b0;
    apply       = 1'b0;
    id_due      = 1'b0;
    natural_due = 1'b0;
    env_due     = 1'b0;
    write       = 1'b0;

    // Command decode: which of the fade, latch and duty steps run.
    unique case (item_i.command)
      CMD_TICK: begin
        if (!cur_i.skip_phase) begin
          nxt.skip_phase = 1'b1;
        end else begin
          nxt.skip_phase = 1'b0;
          if (cur_i.fade_div == FadeDivLast) begin
            nxt.fade_div = '0;
            fade         = 1'b1;
          end else begin
            nxt.fade_div = cur_i.fade_div + 1'b1;
          end

          // Slot strobes; the id slot has priority, then the natural slot.
          if (cur_i.slot == cfg_i.id_slot) begin
            if (cur_i.id_div == IdDivLast) begin
              nxt.id_div = '0;
              id_due     = 1'b1;
            end else begin
              nxt.id_div = cur_i.id_div + 1'b1;
            end
          end else if (cur_i.slot == cfg_i.natural_slot) begin
            nxt.natural_div = ~cur_i.natural_div;
            natural_due     = cur_i.natural_div;
          end else if (cur_i.slot == cfg_i.env_slot) begin
            env_due = 1'b1;
          end

          nxt.update_div = ~cur_i.update_div;
          latch          = cur_i.update_div;
          apply          = cur_i.update_div;
        end
        nxt.slot = slot_next(cur_i.slot);
      end
      CMD_SET: begin
        if (item_i.level > {2'b00, cfg_i.max_level}) begin
          nxt.target = cfg_i.max_level;
        end else begin
          nxt.target = item_i.level[LevelW-1:0];
        end
      end
      CMD_APPLY: begin
        apply = 1'b1;
      end
      CMD_FADE: begin
        fade = 1'b1;
      end
      default: begin
        apply = 1'b0;
      end
    endcase

    // One fade step toward the target.
    if (fade) begin
      if (cur_i.light < cur_i.target) begin
        nxt.light = cur_i.light + 1'b1;
      end else if (cur_i.light > cur_i.target) begin
        nxt.light = cur_i.light - 1'b1;
      end
    end

    // The ON count is taken from the level after this tick's fade.
    if (latch) begin
      if (nxt.light < LevelW'(SeqLen)) begin
        nxt.on_count = nxt.light;
      end else begin
        nxt.on_count = LevelW'(SeqLen);
      end
    end

    // Duty write, only when no duty has been written yet or the value differs from the last one written.
    duty = duty_of(nxt.on_count);
    if (apply && (!cur_i.duty_valid || duty != cur_i.duty)) begin
      write          = 1'b1;
      nxt.duty_valid = 1'b1;
      nxt.duty       = duty;
    end
  end

  assign nxt_o = nxt;

  assign res_o = '{
    duty_write:  write,
    duty_value:  nxt.duty_valid ? nxt.duty : '0,
    id_due:      id_due,
    natural_due: natural_due,
    env_due:     env_due,
    light_now:   nxt.light,
    slot_now:    nxt.slot
  };

endmodule

// ===== tb/sv/tb_slotted_dimmer_fade_pwm.sv =====
`timescale 1ns / 100ps

module tb_slotted_dimmer_fade_pwm;
  import sdfp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam logic [15:0] NoDuty = 16'hFFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready_o;
  sdfp_in_t    in_data;
  logic        out_valid_o;
  logic        out_ready;
  sdfp_out_t   out_data_o;
  logic        cfg_valid;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index;
  logic [5:0]  cfg_data;

  // Dimmer state as the checker expects it.
  logic              half_tick;
  logic [SlotW-1:0]  slot_pos;
  logic [1:0]        fade_cnt;
  logic [1:0]        id_cnt;
  logic              nat_cnt;
  logic              refresh_cnt;
  logic [LevelW-1:0] light_lvl;
  logic [LevelW-1:0] target_lvl;
  logic [LevelW-1:0] on_cnt;
  logic [15:0]       duty_last;

  // Register copies as the checker expects them.
  logic [LevelW-1:0] lim_level;
  logic [SlotW-1:0]  id_slot;
  logic [SlotW-1:0]  nat_slot;
  logic [SlotW-1:0]  env_slot;

  sdfp_out_t   dimmer_results[$];
  sdfp_out_t   want_result;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;

  slotted_dimmer_fade_pwm DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Moves the faded level one step towards the target.
  function automatic void fade_toward();
    if (light_lvl < target_lvl) begin
      light_lvl = light_lvl + 1'b1;
    end else if (light_lvl > target_lvl) begin
      light_lvl = light_lvl - 1'b1;
    end
  endfunction

  // Works out the duty from the latched ON count; true when it is a new value.
  function automatic logic duty_refresh();
    logic [15:0] duty;
    duty = 16'((32'(on_cnt) * DutyFull) / SeqLen);
    if (duty != duty_last) begin
      duty_last = duty;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Expected result of one input transaction; updates the dimmer state.
  function automatic sdfp_out_t dimmer_next(input sdfp_in_t item);
    sdfp_out_t        res;
    logic [SlotW-1:0] here;
    res = '0;
    case (item.command)
      CMD_TICK: begin
        if (!half_tick) begin
          half_tick = 1'b1;
          slot_pos = SlotW'((int'(slot_pos) + 1) % Slots);
        end else begin
          here = slot_pos;
          half_tick = 1'b0;
          if (fade_cnt == FadeDivLast) begin
            fade_cnt = '0;
            fade_toward();
          end else begin
            fade_cnt = fade_cnt + 1'b1;
          end
          // The id slot takes precedence over the natural slot, which beats env.
          if (here == id_slot) begin
            if (id_cnt == IdDivLast) begin
              id_cnt = '0;
              res.id_due = 1'b1;
            end else begin
              id_cnt = id_cnt + 1'b1;
            end
          end else if (here == nat_slot) begin
            if (nat_cnt) begin
              nat_cnt = 1'b0;
              res.natural_due = 1'b1;
            end else begin
              nat_cnt = 1'b1;
            end
          end else if (here == env_slot) begin
            res.env_due = 1'b1;
          end
          if (refresh_cnt) begin
            refresh_cnt = 1'b0;
            on_cnt = (light_lvl < SeqLen) ? light_lvl : LevelW'(SeqLen);
            res.duty_write = duty_refresh();
          end else begin
            refresh_cnt = 1'b1;
          end
          slot_pos = SlotW'((int'(slot_pos) + 1) % Slots);
        end
      end
      CMD_SET: begin
        target_lvl = (item.level > lim_level) ? lim_level : item.level[LevelW-1:0];
      end
      CMD_APPLY: begin
        res.duty_write = duty_refresh();
      end
      default: begin
        fade_toward();
      end
    endcase
    res.duty_value = (duty_last == NoDuty) ? '0 : duty_last[DutyW-1:0];
    res.light_now = light_lvl;
    res.slot_now = slot_pos;
    return res;
  endfunction

  // Sends one input transaction, with an optional idle burst first.
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] lvl);
    sdfp_in_t item;
    item.command = cmd;
    item.level = lvl;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk_i); while (!in_ready_o);
    dimmer_results.push_back(dimmer_next(item));
  endtask

  // Stops the input and waits until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (dimmer_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [5:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MAX_LEVEL:    lim_level = val;
      CFG_ID_SLOT:      id_slot = val[SlotW-1:0];
      CFG_NATURAL_SLOT: nat_slot = val[SlotW-1:0];
      default:          env_slot = val[SlotW-1:0];
    endcase
  endtask

  // Writes all four registers once the block is idle. The unused upper bits of
  // the slot writes carry random values.
  task automatic set_registers(input logic [5:0] lim, input logic [2:0] ids,
                               input logic [2:0] nat, input logic [2:0] env);
    drain_results();
    write_reg(CFG_MAX_LEVEL, lim);
    write_reg(CFG_ID_SLOT, {3'($urandom), ids});
    write_reg(CFG_NATURAL_SLOT, {3'($urandom), nat});
    write_reg(CFG_ENV_SLOT, {3'($urandom), env});
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Picks the amount of idling on both sides for the next phase.
  task automatic choose_idling();
    int unsigned pct[3] = '{0, 20, 40};
    gap_pct = pct[$urandom_range(0, 2)];
    stall_pct = pct[$urandom_range(0, 2)];
  endtask

  // Random mix of commands, mostly ticks, with the odd run of fade steps.
  task automatic run_mix(input int unsigned n);
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_item(CMD_TICK, 8'($urandom));
      end else if (pick < 70) begin
        send_item(CMD_SET, pick[0] ? 8'($urandom) : 8'($urandom_range(0, 64)));
      end else if (pick < 80) begin
        send_item(CMD_APPLY, 8'($urandom));
      end else if (pick < 96) begin
        send_item(CMD_FADE, 8'($urandom));
      end else begin
        repeat ($urandom_range(8, 40)) send_item(CMD_FADE, 8'($urandom));
      end
    end
  endtask

  // Each command with the default registers, level extremes included.
  task automatic test_directed_commands();
    gap_pct = 0;
    stall_pct = 0;
    send_item(CMD_APPLY, 8'h00);
    send_item(CMD_APPLY, 8'hFF);
    send_item(CMD_SET, 8'hFF);
    send_item(CMD_FADE, 8'h00);
    send_item(CMD_FADE, 8'hAA);
    repeat (16) send_item(CMD_TICK, 8'h55);
    send_item(CMD_SET, 8'h00);
    send_item(CMD_FADE, 8'h00);
    send_item(CMD_APPLY, 8'h00);
    send_item(CMD_SET, 8'h01);
  endtask

  // Register extremes and shared slot numbers; the level is driven all the way
  // to its target so that a clamp above the sequence length shows in the duty.
  task automatic test_register_settings();
    logic [5:0] lims[5]  = '{6'd0, 6'd63, 6'd32, 6'd1, 6'd40};
    logic [2:0] idss[5]  = '{3'd0, 3'd7, 3'd7, 3'd3, 3'd2};
    logic [2:0] nats[5]  = '{3'd0, 3'd7, 3'd6, 3'd3, 3'd5};
    logic [2:0] envs[5]  = '{3'd0, 3'd7, 3'd5, 3'd4, 3'd5};
    for (int i = 0; i < 5; i++) begin
      set_registers(lims[i], idss[i], nats[i], envs[i]);
      choose_idling();
      send_item(CMD_SET, 8'hFF);
      while (light_lvl != target_lvl) send_item(CMD_FADE, 8'($urandom));
      run_mix(12);
    end
  endtask

  // Random register values and random traffic.
  task automatic test_random_phases();
    repeat (3) begin
      set_registers(6'($urandom), 3'($urandom), 3'($urandom), 3'($urandom));
      choose_idling();
      run_mix(15);
    end
  endtask

  // Back-to-back transactions with no idling on either side.
  task automatic test_steady_stream();
    set_registers(6'($urandom), 3'($urandom), 3'($urandom), 3'($urandom));
    gap_pct = 0;
    stall_pct = 0;
    run_mix(25);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result side: random stall bursts.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compares each accepted result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (dimmer_results.size() == 0) begin
        $error("result transaction with nothing expected: %p", out_data_o);
        mismatches++;
      end else begin
        want_result = dimmer_results.pop_front();
        check_field("duty_write", want_result.duty_write, out_data_o.duty_write);
        check_field("duty_value", want_result.duty_value, out_data_o.duty_value);
        check_field("id_due", want_result.id_due, out_data_o.id_due);
        check_field("natural_due", want_result.natural_due, out_data_o.natural_due);
        check_field("env_due", want_result.env_due, out_data_o.env_due);
        check_field("light_now", want_result.light_now, out_data_o.light_now);
        check_field("slot_now", want_result.slot_now, out_data_o.slot_now);
      end
    end
  end

  // Guards against a hang anywhere in the run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_MAX_LEVEL;
    cfg_data <= '0;
    half_tick = 1'b0;
    slot_pos = '0;
    fade_cnt = '0;
    id_cnt = '0;
    nat_cnt = 1'b0;
    refresh_cnt = 1'b0;
    light_lvl = '0;
    target_lvl = '0;
    on_cnt = '0;
    duty_last = NoDuty;
    lim_level = CFG_RESET.max_level;
    id_slot = CFG_RESET.id_slot;
    nat_slot = CFG_RESET.natural_slot;
    env_slot = CFG_RESET.env_slot;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_commands();
    test_register_settings();
    test_random_phases();
    test_steady_stream();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
